/* rtl/core/thermal_presence_stove_guard_macros.svh */
`ifndef THERMAL_PRESENCE_STOVE_GUARD_MACROS_SVH
`define THERMAL_PRESENCE_STOVE_GUARD_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define TPSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define TPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tpsg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tpsg_pkg;

    localparam int FRAME_PIXELS_DEF = 64;

    localparam int TEMP_W  = 12;
    localparam int DIFF_W  = 13;
    localparam int COOL_W  = 20;
    localparam int SPAN_W  = 14;
    localparam int SCALE_W = 21;
    localparam int CNT_W   = 7;
    localparam int TICK_W  = 17;
    localparam int THR_W   = 12;
    localparam int DELAY_W = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 12'sh800;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sh7ff;

    // frame maximum above 150 degC / above 40 degC
    localparam logic signed [TEMP_W-1:0] HOT_MAX  = 12'sd600;
    localparam logic signed [TEMP_W-1:0] WARM_MAX = 12'sd160;
    localparam logic signed [DIFF_W-1:0] HOT_DIFF  = 13'sd36;
    localparam logic signed [DIFF_W-1:0] WARM_DIFF = 13'sd16;

    // cool branch: 20*new < 23*pmin and 20*|d| > 2880 - 23*pmin
    localparam logic signed [COOL_W-1:0] COOL_NEW_MUL = 20'sd20;
    localparam logic signed [COOL_W-1:0] COOL_MIN_MUL = 20'sd23;
    localparam logic signed [COOL_W-1:0] COOL_BIAS    = 20'sd2880;

    localparam logic [CNT_W-1:0] NEED_WARM  = 7'd3;
    localparam logic [CNT_W-1:0] NEED_OTHER = 7'd5;
    localparam logic [CNT_W-1:0] CNT_MAX    = 7'd127;

    // cooker off when 100*span < 66*threshold
    localparam logic signed [SCALE_W-1:0] SPAN_MUL = 21'sd100;
    localparam logic signed [SCALE_W-1:0] THR_MUL  = 21'sd66;

    localparam logic [TICK_W-1:0] TICK_MAX = 17'h1ffff;

    localparam logic [THR_W-1:0]   SPAN_THR_RST    = 12'd40;
    localparam logic [DELAY_W-1:0] ALARM_DELAY_RST = 16'd600;

    localparam logic [0:0] CFG_SPAN_THR    = 1'b0;
    localparam logic [0:0] CFG_ALARM_DELAY = 1'b1;

    localparam logic [1:0] GS_PRESENT = 2'd0;
    localparam logic [1:0] GS_ABSENT  = 2'd1;
    localparam logic [1:0] GS_COOKER  = 2'd2;
    localparam logic [1:0] GS_ALARM   = 2'd3;

    typedef enum logic [3:0] {
        ST_PRESENT = 4'b0001,
        ST_ABSENT  = 4'b0010,
        ST_COOKER  = 4'b0100,
        ST_ALARM   = 4'b1000
    } guard_state_t;

    typedef struct packed {
        logic                     motion;
        logic signed [TEMP_W-1:0] fmax;
        logic signed [TEMP_W-1:0] fmin;
    } frame_sum_t;

    // motion in the lowest bit
    typedef struct packed {
        logic       warning;
        logic       alarm_led_level;
        logic       alarm_indicator;
        logic [1:0] guard_state;
        logic       motion;
    } guard_out_t;

    function automatic logic [1:0] state_code(input guard_state_t st);
        logic [1:0] code;
        case (st)
            ST_PRESENT: code = GS_PRESENT;
            ST_ABSENT:  code = GS_ABSENT;
            ST_COOKER:  code = GS_COOKER;
            ST_ALARM:   code = GS_ALARM;
            default:    code = GS_PRESENT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tpsg_frame_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpsg_frame_mem
    import tpsg_pkg::*;
#(
    parameter int DEPTH = FRAME_PIXELS_DEF,
    parameter int AW    = 6
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [TEMP_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [TEMP_W-1:0] rd_data
);

    logic signed [TEMP_W-1:0] mem [DEPTH];
    logic signed [TEMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // a write to the same entry in this cycle is forwarded
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/tpsg_frame_acc.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpsg_frame_acc
    import tpsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     in_range,
    input  logic                     close,
    input  logic signed [TEMP_W-1:0] temp,
    input  logic signed [TEMP_W-1:0] old_temp,
    output frame_sum_t               sum
);

    logic                     prev_valid_reg, prev_valid_next;
    logic signed [TEMP_W-1:0] prev_max_reg, prev_max_next;
    logic signed [TEMP_W-1:0] prev_min_reg, prev_min_next;
    logic signed [TEMP_W-1:0] run_max_reg, run_max_next;
    logic signed [TEMP_W-1:0] run_min_reg, run_min_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     motion_reg, motion_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] mag;
    logic signed [COOL_W-1:0] t_ext, pmin_ext, mag_ext;
    logic signed [COOL_W-1:0] new_scaled, min_scaled, mag_scaled, cool_thr;
    logic                     hot, warm, cool_hit, counts, use_pixel;
    logic [CNT_W-1:0]         cnt_upd, need;
    logic signed [TEMP_W-1:0] max_upd, min_upd;
    logic                     motion;

    always_comb
    begin
        diff = {old_temp[TEMP_W-1], old_temp} - {temp[TEMP_W-1], temp};
        mag  = diff[DIFF_W-1] ? -diff : diff;
        hot  = prev_max_reg > HOT_MAX;
        warm = prev_max_reg > WARM_MAX;

        t_ext      = {{(COOL_W-TEMP_W){temp[TEMP_W-1]}}, temp};
        pmin_ext   = {{(COOL_W-TEMP_W){prev_min_reg[TEMP_W-1]}}, prev_min_reg};
        mag_ext    = {{(COOL_W-DIFF_W){mag[DIFF_W-1]}}, mag};
        new_scaled = t_ext * COOL_NEW_MUL;
        min_scaled = pmin_ext * COOL_MIN_MUL;
        mag_scaled = mag_ext * COOL_NEW_MUL;
        cool_thr   = COOL_BIAS - min_scaled;
        cool_hit   = (new_scaled < min_scaled) && (mag_scaled > cool_thr);

        if (hot)
        begin
            counts = diff > HOT_DIFF;
        end
        else if (warm)
        begin
            counts = diff > WARM_DIFF;
        end
        else
        begin
            counts = cool_hit;
        end

        use_pixel = step && in_range;
        cnt_upd = cnt_reg;
        if (use_pixel && prev_valid_reg && counts && (cnt_reg != CNT_MAX))
        begin
            cnt_upd = cnt_reg + 7'd1;
        end
        max_upd = (use_pixel && (temp > run_max_reg)) ? temp : run_max_reg;
        min_upd = (use_pixel && (temp < run_min_reg)) ? temp : run_min_reg;

        need   = (warm && !hot) ? NEED_WARM : NEED_OTHER;
        motion = prev_valid_reg ? (cnt_upd >= need) : motion_reg;

        sum.motion = motion;
        sum.fmax   = max_upd;
        sum.fmin   = min_upd;

        prev_valid_next = prev_valid_reg;
        prev_max_next   = prev_max_reg;
        prev_min_next   = prev_min_reg;
        run_max_next    = max_upd;
        run_min_next    = min_upd;
        cnt_next        = cnt_upd;
        motion_next     = motion_reg;
        if (step && close)
        begin
            prev_valid_next = 1'b1;
            prev_max_next   = max_upd;
            prev_min_next   = min_upd;
            run_max_next    = TEMP_MIN;
            run_min_next    = TEMP_MAX;
            cnt_next        = '0;
            motion_next     = motion;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_max_reg   <= '0;
            prev_min_reg   <= '0;
            run_max_reg    <= TEMP_MIN;
            run_min_reg    <= TEMP_MAX;
            cnt_reg        <= '0;
            motion_reg     <= 1'b0;
        end
        else
        begin
            prev_valid_reg <= prev_valid_next;
            prev_max_reg   <= prev_max_next;
            prev_min_reg   <= prev_min_next;
            run_max_reg    <= run_max_next;
            run_min_reg    <= run_min_next;
            cnt_reg        <= cnt_next;
            motion_reg     <= motion_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tpsg_guard_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpsg_guard_fsm
    import tpsg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               close,
    input  frame_sum_t         sum,
    input  logic [THR_W-1:0]   span_thr,
    input  logic [DELAY_W-1:0] alarm_delay,
    output guard_out_t         res
);

    guard_state_t      state_reg, state_next;
    logic              timer_reg, timer_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              warned_reg, warned_next;

    logic signed [TEMP_W-1:0]  fmax, fmin;
    logic signed [SPAN_W-1:0]  span, thr_ext;
    logic signed [SCALE_W-1:0] span_ext, thr_wide, span_scaled, thr_scaled;
    logic [TICK_W-1:0]         elapsed_eff;
    logic                      m, wide_span, drop, late, warn;

    always_comb
    begin
        fmax = sum.fmax;
        fmin = sum.fmin;
        m    = sum.motion;
        span = {{(SPAN_W-TEMP_W){fmax[TEMP_W-1]}}, fmax}
             - {{(SPAN_W-TEMP_W){fmin[TEMP_W-1]}}, fmin};
        thr_ext   = {{(SPAN_W-THR_W){1'b0}}, span_thr};
        wide_span = span > thr_ext;

        span_ext    = {{(SCALE_W-SPAN_W){span[SPAN_W-1]}}, span};
        thr_wide    = {{(SCALE_W-THR_W){1'b0}}, span_thr};
        span_scaled = span_ext * SPAN_MUL;
        thr_scaled  = thr_wide * THR_MUL;
        drop        = span_scaled < thr_scaled;

        // a stopped timer restarts from zero on entry
        elapsed_eff = timer_reg ? elapsed_reg : '0;
        late        = elapsed_eff > {{(TICK_W-DELAY_W){1'b0}}, alarm_delay};

        state_next   = state_reg;
        timer_next   = timer_reg;
        elapsed_next = elapsed_reg;
        warned_next  = warned_reg;
        warn         = 1'b0;

        if (tick && timer_reg && (elapsed_reg != TICK_MAX))
        begin
            elapsed_next = elapsed_reg + 17'd1;
        end

        if (close)
        begin
            case (state_reg)
                ST_PRESENT:
                begin
                    if (!m)
                    begin
                        state_next = ST_ABSENT;
                    end
                end
                ST_ABSENT:
                begin
                    if (m)
                    begin
                        state_next = ST_PRESENT;
                    end
                    else if (wide_span && (fmax > WARM_MAX))
                    begin
                        state_next = ST_COOKER;
                    end
                end
                ST_COOKER:
                begin
                    elapsed_next = elapsed_eff;
                    timer_next   = 1'b1;
                    if (drop)
                    begin
                        state_next = ST_ABSENT;
                        timer_next = 1'b0;
                    end
                    else if (late)
                    begin
                        state_next = ST_ALARM;
                        timer_next = 1'b0;
                    end
                    else if (m)
                    begin
                        state_next = ST_PRESENT;
                        timer_next = 1'b0;
                    end
                end
                ST_ALARM:
                begin
                    if (!warned_reg)
                    begin
                        warn        = 1'b1;
                        warned_next = 1'b1;
                    end
                    if (m)
                    begin
                        state_next  = ST_PRESENT;
                        warned_next = 1'b0;
                    end
                end
                default:
                begin
                    state_next = ST_PRESENT;
                end
            endcase
        end

        res.motion          = m;
        res.guard_state     = state_code(state_next);
        res.alarm_indicator = (state_reg == ST_ALARM);
        res.alarm_led_level = (state_reg == ST_ALARM) && !m;
        res.warning         = warn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_PRESENT;
            timer_reg   <= 1'b0;
            elapsed_reg <= '0;
            warned_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            timer_reg   <= timer_next;
            elapsed_reg <= elapsed_next;
            warned_reg  <= warned_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/thermal_presence_stove_guard.sv */
// stove guard fed by a thermal array readout
// input stream s_*: one request per cycle while s_tready is high, either a
//   pixel (s_tuser = 0) with its temperature in s_tdata, s_tlast marking the
//   last pixel of a frame, or a timebase tick (s_tuser = 1)
// output stream m_*: one result per frame, issued for the pixel that carries
//   s_tlast: motion, guard state, alarm indicator, alarm led level, warning
// config port cfg_*: index 0 heat span threshold, index 1 alarm delay; always
//   ready, write only while the stream is idle
// frame result: the accept edge of the last pixel loads the stage register and
//   reads the stored pixel; when the stage fires, the frame is compared, the
//   guard machine steps and the output register that drives m_tvalid is
//   loaded
// throughput: 1 request per cycle while s_tready is high; the frame store takes
//   one read and one write each cycle
// stall: a result held in the output register blocks the input only when the
//   next frame end sits in the stage register; pixels and ticks keep flowing
//   until then, and s_tready follows m_tready while that frame end waits
// reset: rst_n returns all control state and the config registers to defaults;
//   the frame store is not cleared, the first frame after reset is not compared
`timescale 1ns / 1ps
`default_nettype none

`include "thermal_presence_stove_guard_macros.svh"

module thermal_presence_stove_guard
    import tpsg_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [11:0] temperature, [15:12] zero
    input  logic                  s_tuser,  // [0] kind
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // [0] motion, [2:1] guard_state,
                                            // [3] alarm_indicator,
                                            // [4] alarm_led_level, [5] warning
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int PW = $clog2(FRAME_PIXELS + 1);

    logic [THR_W-1:0]   span_thr_reg;
    logic [DELAY_W-1:0] alarm_delay_reg;

    logic [PW-1:0]            ptr_reg, ptr_next;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_kind_reg;
    logic                     s1_last_reg;
    logic                     s1_in_range_reg;
    logic [AW-1:0]            s1_addr_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;

    logic                     out_valid_reg, out_valid_next;
    guard_out_t               out_data_reg;

    logic                     accept, advance, s1_fire, s1_pixel, s1_close;
    logic                     ptr_in_range;
    logic [AW-1:0]            rd_addr;
    logic signed [TEMP_W-1:0] old_temp;
    frame_sum_t               sum;
    guard_out_t               res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_thr_reg    <= SPAN_THR_RST;
            alarm_delay_reg <= ALARM_DELAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPAN_THR:    span_thr_reg    <= cfg_data[THR_W-1:0];
                CFG_ALARM_DELAY: alarm_delay_reg <= cfg_data[DELAY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        s1_pixel = s1_valid_reg && !s1_kind_reg;
        s1_close = s1_pixel && s1_last_reg;
        // only a frame end needs the output register
        advance  = !(s1_close && out_valid_reg && !m_tready);
        s1_fire  = s1_valid_reg && advance;
        s_tready = !s1_valid_reg || advance;
        accept   = s_tvalid && s_tready;

        ptr_in_range = ptr_reg < PW'(FRAME_PIXELS);
        rd_addr      = ptr_in_range ? ptr_reg[AW-1:0] : '0;

        ptr_next = ptr_reg;
        if (accept && !s_tuser)
        begin
            if (s_tlast)
            begin
                ptr_next = '0;
            end
            else if (ptr_in_range)
            begin
                ptr_next = ptr_reg + PW'(1);
            end
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_close)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg     <= s_tuser;
            s1_last_reg     <= s_tlast;
            s1_in_range_reg <= ptr_in_range;
            s1_addr_reg     <= rd_addr;
            s1_temp_reg     <= s_tdata[TEMP_W-1:0];
        end
        if (s1_fire && s1_close)
        begin
            out_data_reg <= res;
        end
    end

    tpsg_frame_mem #(
        .DEPTH (FRAME_PIXELS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (s1_fire && s1_pixel && s1_in_range_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_temp_reg),
        .rd_en   (accept && !s_tuser),
        .rd_addr (rd_addr),
        .rd_data (old_temp)
    );

    tpsg_frame_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_fire && s1_pixel),
        .in_range (s1_in_range_reg),
        .close    (s1_last_reg),
        .temp     (s1_temp_reg),
        .old_temp (old_temp),
        .sum      (sum)
    );

    tpsg_guard_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (s1_fire && s1_kind_reg),
        .close       (s1_fire && s1_close),
        .sum         (sum),
        .span_thr    (span_thr_reg),
        .alarm_delay (alarm_delay_reg),
        .res         (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    `TPSG_ASSERT_NOW(a_s1_no_overwrite, accept && s1_valid_reg, s1_fire,
        "read stage overwritten while holding a request")
    `TPSG_ASSERT_NEXT(a_result_loaded, s1_fire && s1_close, m_tvalid,
        "frame end did not produce a result")
    `TPSG_ASSERT_NOW(a_warning_in_alarm, m_tvalid && m_tdata[5], m_tdata[3],
        "warning issued outside alarm state")

endmodule

`default_nettype wire
